@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the rasterizer RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ rtl/core/plr_pkg.sv @@
package plr_pkg;

  localparam int CoordW   = 24;
  localparam int ScaleW   = 16;
  localparam int SizeW    = 7;
  localparam int PixW     = 6;
  localparam int CharW    = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  // Segment queue between the vertex front end and the line walker.
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ORIGIN_X  = 3'd0,
    CFG_ORIGIN_Y  = 3'd1,
    CFG_SCALE     = 3'd2,
    CFG_COL_LIMIT = 3'd3,
    CFG_ROW_LIMIT = 3'd4,
    CFG_LINE_CHAR = 3'd5
  } cfg_idx_t;

  localparam logic [CoordW-1:0] OriginRst = '0;
  localparam logic [ScaleW-1:0] ScaleRst  = 16'd256;
  localparam logic [SizeW-1:0]  SizeRst   = 7'd64;
  localparam logic [CharW-1:0]  CharRst   = 8'd35;

  typedef struct packed {
    logic signed [CoordW-1:0] world_x;
    logic signed [CoordW-1:0] world_y;
    logic                     new_polyline;
  } vertex_in_t;

  typedef struct packed {
    logic [PixW-1:0]  pixel_x;
    logic [PixW-1:0]  pixel_y;
    logic [CharW-1:0] pixel_char;
    logic             last_pixel;
  } pixel_out_t;

  typedef struct packed {
    logic [CoordW-1:0] origin_x;
    logic [CoordW-1:0] origin_y;
    logic [ScaleW-1:0] scale;
    logic [SizeW-1:0]  col_limit;
    logic [SizeW-1:0]  row_limit;
    logic [CharW-1:0]  line_char;
  } cfg_regs_t;

  // One classified vertex: canvas cell, whether it starts a polyline,
  // and the character to draw with.
  typedef struct packed {
    logic [PixW-1:0]  col;
    logic [PixW-1:0]  row;
    logic             start;
    logic [CharW-1:0] char_code;
  } seg_cmd_t;

endpackage

@@ rtl/core/plr_front.sv @@
`include "assert_macros.svh"

module plr_front #(
  parameter int MAX_CANVAS = 64,
  parameter int FRAC_BITS  = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  plr_pkg::cfg_regs_t cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  plr_pkg::vertex_in_t in_data,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output plr_pkg::seg_cmd_t  cmd_data
);
  import plr_pkg::*;

  localparam int DiffW = CoordW + 1;
  localparam int ProdW = DiffW + ScaleW + 1;
  localparam int Shift = FRAC_BITS + 8;
  localparam logic [SizeW-1:0] MaxLim = SizeW'(MAX_CANVAS);

  // Stage 1: offset and scale. Stage 2: truncate, clamp and classify.
  logic                    s1_v_r, s2_v_r;
  logic signed [ProdW-1:0] px_r, py_r;
  logic                    s1_new_r;
  logic                    have_prev_r;
  seg_cmd_t                s2_cmd_r;

  logic                    s1_ready, s2_ready;
  logic signed [DiffW-1:0] diff_x, diff_y;
  logic signed [ScaleW:0]  scale_s;
  logic signed [ProdW-1:0] px_nxt, py_nxt;
  logic [PixW-1:0]         col_nxt, row_nxt;

  function automatic logic [SizeW-1:0] size_limit(input logic [SizeW-1:0] reg_val);
    logic [SizeW-1:0] n;
    n = reg_val;
    if (n == '0) n = SizeW'(1);
    if (n > MaxLim) n = MaxLim;
    return n;
  endfunction

  function automatic logic [PixW-1:0] to_cell(input logic signed [ProdW-1:0] p,
                                              input logic [SizeW-1:0] size_reg);
    logic [SizeW-1:0] lim;
    logic [ProdW-1:0] c;
    lim = size_limit(size_reg);
    c   = $unsigned(p) >> Shift;
    if (p[ProdW-1]) return '0;
    if (c >= ProdW'(lim)) return PixW'(lim - SizeW'(1));
    return c[PixW-1:0];
  endfunction

  assign s2_ready = !s2_v_r || cmd_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_ready = s1_ready;

  assign diff_x  = DiffW'(in_data.world_x) - DiffW'($signed(cfg.origin_x));
  assign diff_y  = DiffW'(in_data.world_y) - DiffW'($signed(cfg.origin_y));
  assign scale_s = $signed({1'b0, cfg.scale});
  assign px_nxt  = ProdW'(diff_x) * ProdW'(scale_s);
  assign py_nxt  = ProdW'(diff_y) * ProdW'(scale_s);

  assign col_nxt = to_cell(px_r, cfg.col_limit);
  assign row_nxt = to_cell(py_r, cfg.row_limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      have_prev_r <= 1'b0;
    end else begin
      if (s1_ready) s1_v_r <= in_valid;
      if (s2_ready) s2_v_r <= s1_v_r;
      if (s2_ready && s1_v_r) have_prev_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      px_r     <= px_nxt;
      py_r     <= py_nxt;
      s1_new_r <= in_data.new_polyline;
    end
    if (s2_ready && s1_v_r) begin
      s2_cmd_r.col       <= col_nxt;
      s2_cmd_r.row       <= row_nxt;
      s2_cmd_r.start     <= s1_new_r || !have_prev_r;
      s2_cmd_r.char_code <= cfg.line_char;
    end
  end

  assign cmd_valid = s2_v_r;
  assign cmd_data  = s2_cmd_r;

  // Input is held off only while a product waits behind a stalled stage 2.
  `ASSERT_AT(a_front_stall_cause, clk, rst_n, !in_ready |-> (s1_v_r && s2_v_r && !cmd_ready))

endmodule

@@ rtl/core/plr_fifo.sv @@
`include "assert_macros.svh"

module plr_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  plr_pkg::seg_cmd_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output plr_pkg::seg_cmd_t pop_data
);
  import plr_pkg::*;

  seg_cmd_t             mem_r [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QueuePtrW:0]   count_r;
  logic                 do_push, do_pop;

  assign push_ready = (count_r != (QueuePtrW+1)'(QueueDepth));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QueuePtrW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QueuePtrW'(1);
      if (do_push && !do_pop) count_r <= count_r + (QueuePtrW+1)'(1);
      else if (do_pop && !do_push) count_r <= count_r - (QueuePtrW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  // Occupancy always agrees with the pointer distance.
  `ASSERT_AT(a_fifo_ptr_count, clk, rst_n,
             (wr_ptr_r - rd_ptr_r) == count_r[QueuePtrW-1:0])

endmodule

@@ rtl/core/plr_walker.sv @@
`include "assert_macros.svh"

module plr_walker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  plr_pkg::seg_cmd_t  cmd_data,
  output logic               out_valid,
  input  logic               out_ready,
  output plr_pkg::pixel_out_t out_data
);
  import plr_pkg::*;

  localparam int ErrW = PixW + 3;
  localparam int E2W  = ErrW + 1;

  typedef enum logic [1:0] {
    W_IDLE = 2'b01,
    W_WALK = 2'b10
  } walk_state_t;

  walk_state_t          state_r, state_nxt;
  logic [PixW-1:0]      prev_col_r, prev_row_r;
  logic [PixW-1:0]      x_r, y_r, x2_r, y2_r;
  logic [PixW-1:0]      dx_r, dy_r;
  logic                 sx_neg_r, sy_neg_r;
  logic signed [ErrW-1:0] err_r;
  logic [CharW-1:0]     char_r;
  logic                 out_valid_r;
  pixel_out_t           out_data_r;

  logic                 emit, done;
  logic signed [E2W-1:0] e2, dx_s, dy_s;
  logic signed [ErrW-1:0] err_nxt;
  logic [PixW-1:0]      x_nxt, y_nxt;
  logic [PixW-1:0]      init_dx, init_dy;

  assign emit = (state_r == W_WALK) && (!out_valid_r || out_ready);
  assign done = (x_r == x2_r) && (y_r == y2_r);
  assign cmd_ready = (state_r == W_IDLE);

  assign init_dx = (cmd_data.col > prev_col_r) ? cmd_data.col - prev_col_r
                                               : prev_col_r - cmd_data.col;
  assign init_dy = (cmd_data.row > prev_row_r) ? cmd_data.row - prev_row_r
                                               : prev_row_r - cmd_data.row;

  // One Bresenham step; both tests use the doubled error from before the step.
  always_comb begin
    dx_s    = $signed({{(E2W-PixW){1'b0}}, dx_r});
    dy_s    = $signed({{(E2W-PixW){1'b0}}, dy_r});
    e2      = E2W'(err_r) <<< 1;
    err_nxt = err_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    if (e2 > -dy_s) begin
      err_nxt = err_nxt - ErrW'(dy_s);
      x_nxt   = sx_neg_r ? x_r - PixW'(1) : x_r + PixW'(1);
    end
    if (e2 < dx_s) begin
      err_nxt = err_nxt + ErrW'(dx_s);
      y_nxt   = sy_neg_r ? y_r - PixW'(1) : y_r + PixW'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      W_IDLE: begin
        if (cmd_valid && !cmd_data.start) state_nxt = W_WALK;
      end
      W_WALK: begin
        if (emit && done) state_nxt = W_IDLE;
      end
      default: state_nxt = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= W_IDLE;
      out_valid_r <= 1'b0;
      prev_col_r  <= '0;
      prev_row_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (state_r == W_IDLE && cmd_valid) begin
        prev_col_r <= cmd_data.col;
        prev_row_r <= cmd_data.row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == W_IDLE && cmd_valid && !cmd_data.start) begin
      x_r      <= prev_col_r;
      y_r      <= prev_row_r;
      x2_r     <= cmd_data.col;
      y2_r     <= cmd_data.row;
      dx_r     <= init_dx;
      dy_r     <= init_dy;
      sx_neg_r <= !(prev_col_r < cmd_data.col);
      sy_neg_r <= !(prev_row_r < cmd_data.row);
      err_r    <= ErrW'($signed({3'b000, init_dx})) - ErrW'($signed({3'b000, init_dy}));
      char_r   <= cmd_data.char_code;
    end else if (emit && !done) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      err_r <= err_nxt;
    end
    if (emit) begin
      out_data_r.pixel_x    <= x_r;
      out_data_r.pixel_y    <= y_r;
      out_data_r.pixel_char <= char_r;
      out_data_r.last_pixel <= done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The walk moves at most one cell per axis per pixel.
  `ASSERT_AT(a_walk_unit_step_x, clk, rst_n,
             (emit && !done) |=> (x_r == $past(x_r) || x_r == $past(x_r) + PixW'(1) ||
                                  x_r == $past(x_r) - PixW'(1)))
  `ASSERT_AT(a_walk_unit_step_y, clk, rst_n,
             (emit && !done) |=> (y_r == $past(y_r) || y_r == $past(y_r) + PixW'(1) ||
                                  y_r == $past(y_r) - PixW'(1)))
  // A walk never ends without handing out a flagged final pixel.
  `ASSERT_AT(a_walk_ends_flagged, clk, rst_n,
             (state_r == W_WALK && state_nxt == W_IDLE) |=> (out_valid_r && out_data_r.last_pixel))

endmodule

@@ rtl/core/polyline_line_rasterizer_top.sv @@
// Polyline rasterizer: maps world-space vertices to canvas cells and draws
// each polyline segment as a Bresenham line, one pixel word per cycle when not stalled.
// Input channel (in_valid/in_ready/in_data): one vertex word per handshake.
// A vertex with new_polyline set, or the first vertex after reset, is only
// stored and produces no output. Every other vertex draws from the stored
// cell to its own cell, both ends included, and last_pixel marks the end.
// Output channel (out_valid/out_ready/out_data): one pixel word per handshake.
// Configuration port: cfg_we writes cfg_wdata into register cfg_index at the
// clock edge; write it only while no vertex is in flight.
// The first pixel of a segment is offered once its vertex has passed the
// two front-end stages, the segment queue and the walker set-up in W_IDLE.
// A segment holds the walker for that set-up and one step per pixel, with
// up to 64 pixels on a 64-cell canvas; the walker's one-pixel-per-cycle
// step loop sets the throughput. The front end keeps accepting vertices
// into a four-entry queue while a line is drawn.
// When the receiver stalls, the pixel stays in the output register and the
// walker pauses; the queue then fills and in_ready drops.
// Reset (synchronous, rst_n low) restores the register defaults, empties the
// pipeline and the queue, and forgets the stored vertex.
module polyline_line_rasterizer_top #(
  parameter int MAX_CANVAS = 64,
  parameter int FRAC_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  plr_pkg::vertex_in_t           in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output plr_pkg::pixel_out_t           out_data,
  input  logic                          cfg_we,
  input  logic [plr_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [plr_pkg::CfgDataW-1:0]  cfg_wdata
);
  import plr_pkg::*;

  cfg_regs_t cfg_r;
  logic      cmd_valid_f, cmd_ready_f;
  seg_cmd_t  cmd_data_f;
  logic      cmd_valid_q, cmd_ready_q;
  seg_cmd_t  cmd_data_q;

  // Register file. Writes to indexes beyond the list fall through the
  // default arm and change nothing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x  <= OriginRst;
      cfg_r.origin_y  <= OriginRst;
      cfg_r.scale     <= ScaleRst;
      cfg_r.col_limit <= SizeRst;
      cfg_r.row_limit <= SizeRst;
      cfg_r.line_char <= CharRst;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X:  cfg_r.origin_x  <= cfg_wdata[CoordW-1:0];
        CFG_ORIGIN_Y:  cfg_r.origin_y  <= cfg_wdata[CoordW-1:0];
        CFG_SCALE:     cfg_r.scale     <= cfg_wdata[ScaleW-1:0];
        CFG_COL_LIMIT: cfg_r.col_limit <= cfg_wdata[SizeW-1:0];
        CFG_ROW_LIMIT: cfg_r.row_limit <= cfg_wdata[SizeW-1:0];
        CFG_LINE_CHAR: cfg_r.line_char <= cfg_wdata[CharW-1:0];
        default: ;
      endcase
    end
  end

  // Front end: scale, clamp and classify each vertex.
  plr_front #(
    .MAX_CANVAS(MAX_CANVAS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cmd_valid(cmd_valid_f),
    .cmd_ready(cmd_ready_f),
    .cmd_data (cmd_data_f)
  );

  // Queue of classified vertices so the front end can run ahead of drawing.
  plr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(cmd_valid_f),
    .push_ready(cmd_ready_f),
    .push_data (cmd_data_f),
    .pop_valid (cmd_valid_q),
    .pop_ready (cmd_ready_q),
    .pop_data  (cmd_data_q)
  );

  // Back end: holds the stored cell and walks each segment pixel by pixel.
  plr_walker u_walker (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid_q),
    .cmd_ready(cmd_ready_q),
    .cmd_data (cmd_data_q),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

@@ test/plr_pixel_checker.sv @@
`timescale 1ns / 1ps

// Watches the vertex, pixel and register ports, works out the pixel words
// that every accepted vertex must produce, and compares them in order.
module plr_pixel_checker #(
  parameter int MaxCanvas = 64,
  parameter int FracBits  = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  plr_pkg::vertex_in_t           in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  plr_pkg::pixel_out_t           out_data,
  input  logic                          cfg_we,
  input  logic [plr_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [plr_pkg::CfgDataW-1:0]  cfg_wdata,
  output int unsigned                   fail_count,
  output int unsigned                   pixels_owed
);
  import plr_pkg::*;

  cfg_regs_t       regs;
  logic [PixW-1:0] prev_col;
  logic [PixW-1:0] prev_row;
  logic            have_prev;
  pixel_out_t      pending_pixels[$];

  // Negative offsets land on cell 0; the rest is truncated and saturated.
  function automatic logic [PixW-1:0] world_to_cell(input logic [CoordW-1:0] world,
                                                     input logic [CoordW-1:0] origin,
                                                     input logic [ScaleW-1:0] scale,
                                                     input logic [SizeW-1:0]  size);
    longint offset;
    longint product;
    longint pos;
    longint limit;
    offset  = longint'($signed(world)) - longint'($signed(origin));
    product = offset * longint'(scale);
    limit   = longint'(size);
    if (limit == 0) limit = 1;
    if (limit > MaxCanvas) limit = MaxCanvas;
    if (product < 0) return '0;
    pos = product >>> (FracBits + 8);
    if (pos >= limit) pos = limit - 1;
    return PixW'(pos);
  endfunction

  // Bresenham walk from the stored cell, both ends included.
  task automatic trace_segment(input int x_to, input int y_to, input logic [CharW-1:0] ch);
    int         x;
    int         y;
    int         dx;
    int         dy;
    int         sx;
    int         sy;
    int         err;
    int         e2;
    int         n;
    bit         done;
    pixel_out_t px;
    x    = prev_col;
    y    = prev_row;
    dx   = (x_to > x) ? x_to - x : x - x_to;
    dy   = (y_to > y) ? y_to - y : y - y_to;
    sx   = (x < x_to) ? 1 : -1;
    sy   = (y < y_to) ? 1 : -1;
    err  = dx - dy;
    n    = 0;
    done = 1'b0;
    while (!done && n < MaxCanvas) begin
      done          = (x == x_to) && (y == y_to);
      px.pixel_x    = PixW'(x);
      px.pixel_y    = PixW'(y);
      px.pixel_char = ch;
      px.last_pixel = done;
      pending_pixels.push_back(px);
      n++;
      if (!done) begin
        e2 = 2 * err;
        if (e2 > -dy) begin
          err -= dy;
          x   += sx;
        end
        if (e2 < dx) begin
          err += dx;
          y   += sy;
        end
      end
    end
  endtask

  task automatic take_vertex(input vertex_in_t v);
    logic [PixW-1:0] col;
    logic [PixW-1:0] row;
    col = world_to_cell(v.world_x, regs.origin_x, regs.scale, regs.col_limit);
    row = world_to_cell(v.world_y, regs.origin_y, regs.scale, regs.row_limit);
    if (!v.new_polyline && have_prev) trace_segment(col, row, regs.line_char);
    prev_col  = col;
    prev_row  = row;
    have_prev = 1'b1;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    case (idx)
      CFG_ORIGIN_X:  regs.origin_x  = data[CoordW-1:0];
      CFG_ORIGIN_Y:  regs.origin_y  = data[CoordW-1:0];
      CFG_SCALE:     regs.scale     = data[ScaleW-1:0];
      CFG_COL_LIMIT: regs.col_limit = data[SizeW-1:0];
      CFG_ROW_LIMIT: regs.row_limit = data[SizeW-1:0];
      CFG_LINE_CHAR: regs.line_char = data[CharW-1:0];
      default: ;
    endcase
  endtask

  task automatic report_field(input string name, input logic [CharW-1:0] want,
                              input logic [CharW-1:0] got);
    fail_count++;
    $display("%0t: pixel word %s mismatch, expected %0d, got %0d", $time, name, want, got);
  endtask

  task automatic check_pixel(input pixel_out_t got);
    pixel_out_t want;
    if (pending_pixels.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected pixel word, expected none, got x=%0d y=%0d char=%0d last=%0b",
               $time, got.pixel_x, got.pixel_y, got.pixel_char, got.last_pixel);
      return;
    end
    want = pending_pixels.pop_front();
    if (got.pixel_x !== want.pixel_x) report_field("pixel_x", want.pixel_x, got.pixel_x);
    if (got.pixel_y !== want.pixel_y) report_field("pixel_y", want.pixel_y, got.pixel_y);
    if (got.pixel_char !== want.pixel_char) begin
      report_field("pixel_char", want.pixel_char, got.pixel_char);
    end
    if (got.last_pixel !== want.last_pixel) begin
      report_field("last_pixel", want.last_pixel, got.last_pixel);
    end
  endtask

  // Outputs are checked before the new vertex is added, so a word leaving at
  // the same edge can never be matched against pixels that vertex just caused.
  always @(posedge clk) begin
    if (!rst_n) begin
      regs.origin_x  = OriginRst;
      regs.origin_y  = OriginRst;
      regs.scale     = ScaleRst;
      regs.col_limit = SizeRst;
      regs.row_limit = SizeRst;
      regs.line_char = CharRst;
      prev_col       = '0;
      prev_row       = '0;
      have_prev      = 1'b0;
      fail_count     = 0;
      pending_pixels.delete();
    end else begin
      if (out_valid && out_ready) check_pixel(out_data);
      if (cfg_we) write_reg(cfg_index, cfg_wdata);
      if (in_valid && in_ready) take_vertex(in_data);
    end
    pixels_owed = pending_pixels.size();
  end

endmodule

@@ test/tb_polyline_line_rasterizer_top.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the polyline rasterizer. The checker beside the
// block does all prediction and comparison; this module only drives the
// ports and decides when the run is over.
module tb_polyline_line_rasterizer_top;
  import plr_pkg::*;

  localparam int MaxCanvas = 64;
  localparam int FracBits  = 8;

  // One canvas cell per world unit at scale 1.0, as a product of world fraction units and scale units.
  localparam longint CellUnit = longint'(1) << (FracBits + 8);

  // Indexes past the last register; writes there must change nothing.
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 3'd7;

  localparam int VertexBudget  = 450;
  // Start vertices leave nothing to wait for, so after the last pixel word
  // we still give the front end and the segment queue time to empty.
  localparam int DrainWait     = 20;
  localparam int HoldOffCycles = 300;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  vertex_in_t           in_data;
  logic                 out_valid;
  logic                 out_ready;
  pixel_out_t           out_data;
  logic                 cfg_we;
  logic [CfgIdxW-1:0]   cfg_index;
  logic [CfgDataW-1:0]  cfg_wdata;
  int unsigned          fail_count;
  int unsigned          pixels_owed;

  // Handshakes seen at the last rising edge, read back at the falling edge.
  logic in_took;
  logic out_took;

  // Our own copy of the settings, used only to aim vertices at the canvas.
  logic [CoordW-1:0] aim_origin_x;
  logic [CoordW-1:0] aim_origin_y;
  logic [ScaleW-1:0] aim_scale;
  logic [SizeW-1:0]  aim_width;
  logic [SizeW-1:0]  aim_height;
  int unsigned       vertices_sent;
  bit                no_gaps;

  polyline_line_rasterizer_top #(
    .MAX_CANVAS(MaxCanvas),
    .FRAC_BITS (FracBits)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  plr_pixel_checker #(
    .MaxCanvas(MaxCanvas),
    .FracBits (FracBits)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pixels_owed(pixels_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_took  <= 1'b0;
      out_took <= 1'b0;
    end else begin
      in_took  <= in_valid && in_ready;
      out_took <= out_valid && out_ready;
    end
  end

  // Idle length for either side: mostly none, often a few cycles, and now
  // and then a long gap.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    if (roll < 98) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  // The number of cells a size register really gives.
  function automatic int size_in_use(input logic [SizeW-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MaxCanvas) return MaxCanvas;
    return int'(raw);
  endfunction

  // World coordinate that lands on the given cell (or just past the canvas)
  // under the current origin and scale. With scale zero every vertex maps to
  // cell 0, so any value serves.
  function automatic logic [CoordW-1:0] aim_coord(input int target,
                                                  input logic [CoordW-1:0] origin);
    longint stride;
    longint offset;
    if (aim_scale == 0) return CoordW'($urandom);
    stride = CellUnit / longint'(aim_scale);
    offset = longint'(target) * stride + longint'($urandom_range(stride - 1, 0));
    return CoordW'(longint'($signed(origin)) + offset);
  endfunction

  // Mostly vertices aimed at or slightly beyond the canvas so that lines of
  // every slope and the clamped borders get drawn; one in ten is raw noise
  // over the whole 24-bit range.
  function automatic vertex_in_t random_vertex();
    vertex_in_t  v;
    int unsigned roll;
    roll           = $urandom_range(99);
    v.new_polyline = (roll < 12);
    if (roll >= 90) begin
      v.world_x = CoordW'($urandom);
      v.world_y = CoordW'($urandom);
    end else begin
      v.world_x = aim_coord(int'($urandom_range(size_in_use(aim_width) + 3)) - 2, aim_origin_x);
      v.world_y = aim_coord(int'($urandom_range(size_in_use(aim_height) + 3)) - 2, aim_origin_y);
    end
    return v;
  endfunction

  // Whole cell coordinates; only meaningful with origin 0 and scale 1.0.
  function automatic vertex_in_t at_cell(input int cx, input int cy, input bit start);
    vertex_in_t v;
    v.world_x      = CoordW'(cx <<< FracBits);
    v.world_y      = CoordW'(cy <<< FracBits);
    v.new_polyline = start;
    return v;
  endfunction

  // Offers one vertex word and returns at the falling edge after it was
  // taken. Valid stays high into the next word when no gap follows.
  task automatic send_vertex(input vertex_in_t v);
    int unsigned gap;
    gap = no_gaps ? 0 : idle_len();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = v;
    @(negedge clk);
    while (!in_took) @(negedge clk);
    vertices_sent++;
  endtask

  // Stops offering and waits until every predicted pixel word has arrived
  // and the pipeline has had time to swallow any trailing start vertices.
  task automatic drain();
    in_valid = 1'b0;
    while (pixels_owed != 0) @(negedge clk);
    repeat (DrainWait) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    case (idx)
      CFG_ORIGIN_X:  aim_origin_x = data[CoordW-1:0];
      CFG_ORIGIN_Y:  aim_origin_y = data[CoordW-1:0];
      CFG_SCALE:     aim_scale    = data[ScaleW-1:0];
      CFG_COL_LIMIT: aim_width    = data[SizeW-1:0];
      CFG_ROW_LIMIT: aim_height   = data[SizeW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Rewrites all six registers once the block is idle. The narrow registers
  // get random bits above their width, which the block must drop. The stored
  // vertex is kept, so the next vertex may continue the old polyline.
  task automatic configure(input logic [CoordW-1:0] ox, input logic [CoordW-1:0] oy,
                           input logic [ScaleW-1:0] sc, input logic [SizeW-1:0] w,
                           input logic [SizeW-1:0] h, input logic [CharW-1:0] ch);
    logic [CfgDataW-1:0] junk;
    drain();
    junk = CfgDataW'($urandom);
    put_reg(CFG_ORIGIN_X, ox);
    put_reg(CFG_ORIGIN_Y, oy);
    put_reg(CFG_SCALE, {junk[CfgDataW-1:ScaleW], sc});
    put_reg(CFG_COL_LIMIT, {junk[CfgDataW-1:SizeW], w});
    put_reg(CFG_ROW_LIMIT, {~junk[CfgDataW-1:SizeW], h});
    put_reg(CFG_LINE_CHAR, {junk[CfgDataW-1:CharW], ch});
  endtask

  // Canvas sizes: mostly in range, sometimes one cell, zero or too large.
  function automatic logic [SizeW-1:0] random_size();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 80) return SizeW'($urandom_range(MaxCanvas, 2));
    if (roll < 90) return SizeW'(1);
    if (roll < 95) return '0;
    return SizeW'($urandom_range(127, MaxCanvas + 1));
  endfunction

  // Scales between a quarter and four cells per unit keep most lines on the
  // canvas; the rest reach the extremes.
  function automatic logic [ScaleW-1:0] random_scale();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return ScaleW'($urandom_range(1024, 64));
    if (roll < 85) return ScaleW'($urandom_range(65535));
    if (roll < 90) return '0;
    if (roll < 95) return ScaleW'(1);
    return '1;
  endfunction

  task automatic random_setting();
    configure(CoordW'($urandom), CoordW'($urandom), random_scale(), random_size(),
              random_size(), CharW'($urandom));
    if ($urandom_range(3) == 0) begin
      put_reg($urandom_range(1) ? CfgIdxSpareHi : CfgIdxSpareLo, CfgDataW'($urandom));
    end
  endtask

  // Pixel receiver. Per cycle it either keeps up a stall, holds ready high
  // through a calm stretch, or draws a fresh idle length. Twice in the run it
  // holds off for a long stretch while the sender keeps offering vertices,
  // so the segment queue fills and the block must stall its input.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned taken;
    int unsigned holds_done;
    stall_left = 0;
    calm_left  = 0;
    taken      = 0;
    holds_done = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (out_took) taken++;
      if (stall_left != 0) begin
        stall_left--;
        out_ready = 1'b0;
      end else if ((holds_done == 0 && taken >= 400) || (holds_done == 1 && taken >= 6000)) begin
        holds_done++;
        stall_left = HoldOffCycles - 1;
        out_ready  = 1'b0;
      end else if (calm_left != 0) begin
        calm_left--;
        out_ready = 1'b1;
      end else if ($urandom_range(99) < 5) begin
        calm_left = $urandom_range(150, 40);
        out_ready = 1'b1;
      end else begin
        stall_left = idle_len();
        out_ready  = (stall_left == 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  initial begin : stimulus
    vertex_in_t  v;
    vertex_in_t  last_v;
    int unsigned phase_len;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_ORIGIN_X;
    cfg_wdata     = '0;
    aim_origin_x  = OriginRst;
    aim_origin_y  = OriginRst;
    aim_scale     = ScaleRst;
    aim_width     = SizeRst;
    aim_height    = SizeRst;
    vertices_sent = 0;
    no_gaps       = 1'b1;
    last_v        = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: origin 0, one cell per world unit, full 64x64 canvas.
    // The first words go back to back. Nothing is stored yet, so the first
    // vertex only sets the start point even though it does not ask to.
    send_vertex(at_cell(10, 10, 1'b0));
    send_vertex(at_cell(0, 0, 1'b0));
    // Full-length horizontal, vertical and diagonal lines.
    send_vertex(at_cell(63, 0, 1'b0));
    send_vertex(at_cell(63, 63, 1'b0));
    send_vertex(at_cell(0, 0, 1'b0));
    // Same cell again: a one-pixel segment.
    send_vertex(at_cell(0, 0, 1'b0));
    // Coordinate extremes: the largest value clamps to the far edge and the
    // most negative one to cell 0.
    send_vertex({24'h7FFFFF, 24'h800000, 1'b0});
    send_vertex({24'h800000, 24'h7FFFFF, 1'b0});
    no_gaps = 1'b0;
    // A new polyline, then a steep and a shallow line.
    send_vertex(at_cell(5, 40, 1'b1));
    send_vertex(at_cell(20, 3, 1'b0));
    send_vertex(at_cell(61, 9, 1'b0));
    // Fraction bits never move a vertex off its cell.
    send_vertex({24'h001EFF, 24'h001E80, 1'b0});
    // Start on minus one (cell 0) and one cell past the bottom edge.
    send_vertex({24'hFFFFFF, 24'h004000, 1'b1});
    send_vertex(at_cell(64, 1, 1'b0));

    // Extreme settings, changed in the middle of a polyline: the stored cell
    // keeps its old mapping. Width zero acts as one column and a height over
    // the limit acts as the full canvas.
    configure(24'h7FFFFF, 24'h800000, 16'hFFFF, 7'd0, 7'd127, 8'hFF);
    send_vertex(random_vertex());
    send_vertex({24'h800000, 24'h7FFFFF, 1'b0});
    send_vertex({24'h7FFFFF, 24'h800000, 1'b0});

    // Scale zero puts every vertex on the origin cell.
    configure(24'h000000, 24'h000000, 16'h0000, 7'd65, 7'd1, 8'h00);
    send_vertex(random_vertex());
    send_vertex({24'h7FFFFF, 24'h7FFFFF, 1'b0});
    send_vertex({24'h800000, 24'h800000, 1'b0});

    // Smallest nonzero scale, origin at the far corners of the world.
    configure(24'h800000, 24'h7FFFFF, 16'h0001, 7'd64, 7'd64, 8'hA5);
    send_vertex(at_cell(0, 0, 1'b1));
    send_vertex({24'h7FFFFF, 24'h000000, 1'b0});
    send_vertex(random_vertex());

    // Writes to indexes with no register behind them must be ignored.
    drain();
    put_reg(CfgIdxSpareLo, 24'hFFFFFF);
    put_reg(CfgIdxSpareHi, 24'h5A5A5A);
    send_vertex(random_vertex());
    send_vertex(random_vertex());

    // Random phases: each begins once the block is idle with a fresh set of
    // registers, and a quarter of them offer words with no gaps at all.
    while (vertices_sent < VertexBudget) begin
      random_setting();
      no_gaps   = ($urandom_range(3) == 0);
      phase_len = $urandom_range(70, 40);
      repeat (phase_len) begin
        if ($urandom_range(99) < 4) begin
          v              = last_v;
          v.new_polyline = 1'b0;
        end else begin
          v = random_vertex();
        end
        send_vertex(v);
        last_v = v;
      end
    end

    drain();
    if (fail_count == 0 && pixels_owed == 0) begin
      $display("polyline_line_rasterizer_top test passed");
    end else begin
      $display("polyline_line_rasterizer_top test failed");
    end
    $finish;
  end

  // The slowest correct run is about 500 vertices of 64 pixel words each,
  // every word waiting out the longest receiver stall, plus sender gaps and
  // the idle waits between phases. The watchdog allows about four times that.
  initial begin : watchdog
    #60_000_000;
    $display("polyline_line_rasterizer_top test failed");
    $finish;
  end

endmodule
